// ===== design/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants of the crossover regime detector
// Widths, fixed thresholds, register indexes and divider request types.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int MAX_PERIOD = 64;
  localparam int MIN_GAP    = 3277;
  localparam int RING_DEPTH = 2 * MAX_PERIOD;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int PER_W      = $clog2(MAX_PERIOD + 1);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int PRICE_W  = 32;
  localparam int TREND_W  = 17;
  localparam int LVL_W    = 16;
  localparam int REGIME_W = 2;
  localparam int SUM_W    = PRICE_W + $clog2(MAX_PERIOD);

  localparam int BUY_LO    = 33423;
  localparam int BUY_HI    = 58982;
  localparam int SELL_LO   = 6554;
  localparam int SELL_HI   = 32113;
  localparam int TREND_ONE = 32768;
  localparam int TH_W      = 20;

  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DW    = 16;

  localparam logic [6:0]  RST_FAST_PERIOD = 7'd5;
  localparam logic [6:0]  RST_SLOW_PERIOD = 7'd20;
  localparam logic [7:0]  RST_MIN_BARS    = 8'd20;
  localparam logic        RST_ADAPT       = 1'b1;
  localparam logic [15:0] RST_BASE_BUY    = 16'd39322;
  localparam logic [15:0] RST_BASE_SELL   = 16'd26214;
  localparam logic [15:0] RST_UP_BIAS     = 16'd3277;
  localparam logic [15:0] RST_DOWN_BIAS   = 16'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_PERIOD = 4'd0,
    CFG_SLOW_PERIOD = 4'd1,
    CFG_MIN_BARS    = 4'd2,
    CFG_ADAPT       = 4'd3,
    CFG_BASE_BUY    = 4'd4,
    CFG_BASE_SELL   = 4'd5,
    CFG_UP_BIAS     = 4'd6,
    CFG_DOWN_BIAS   = 4'd7
  } cfg_idx_e;

  typedef enum logic [REGIME_W-1:0] {
    REGIME_NEUTRAL = 2'd0,
    REGIME_UP      = 2'd1,
    REGIME_DOWN    = 2'd2
  } regime_e;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/scr_if.sv =====
// ----------------------------------------------------------------------------
// scr_if: stream and configuration channels of the regime detector
// Price input, result output and register write channels.
// ----------------------------------------------------------------------------
interface scr_in_if;
  logic                         valid;
  logic                         ready;
  logic [scr_pkg::PRICE_W-1:0]  price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface scr_out_if;
  logic                                valid;
  logic                                ready;
  logic [scr_pkg::PRICE_W-1:0]         fast_average;
  logic [scr_pkg::PRICE_W-1:0]         slow_average;
  logic signed [scr_pkg::TREND_W-1:0]  trend_ratio;
  logic [scr_pkg::REGIME_W-1:0]        regime;
  logic [scr_pkg::LVL_W-1:0]           buy_level;
  logic [scr_pkg::LVL_W-1:0]           sell_level;

  modport source (output valid, output fast_average, output slow_average,
                  output trend_ratio, output regime, output buy_level,
                  output sell_level, input ready);
  modport sink   (input valid, input fast_average, input slow_average,
                  input trend_ratio, input regime, input buy_level,
                  input sell_level, output ready);
endinterface

interface scr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scr_pkg::CFG_IDX_W-1:0] index;
  logic [scr_pkg::CFG_DW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/sma_crossover_regime_detector.sv =====
// ----------------------------------------------------------------------------
// sma_crossover_regime_detector: dual moving-average crossover regime detector
// Price history ring, fast/slow averages, trend strength, regime and levels.
// ----------------------------------------------------------------------------
// One input beat per bar gives one result beat. While the history is shorter
// than the slow period a bar goes from the accepted beat through setup and
// finish back to idle. Once it is full, a bar sums the newest prices out of
// the ring RAM over the longer of the two periods in use, one read a cycle,
// then runs two or three divisions on the shared one-bit-per-cycle divider
// (fast mean, slow mean, and trend strength when the slow mean is nonzero),
// and posts the result. A result still waiting in the output register holds
// the sequencer in its last state until the result beat leaves. The input is
// ready only between bars; a finished result may wait in the output register
// while the next bar is taken. The ring needs no clearing after reset.
// Registers may be written only while the block is idle.
module sma_crossover_regime_detector (
  input  logic      clk_i,
  input  logic      rst_ni,
  scr_in_if.sink    in_i,
  scr_out_if.source out_o,
  scr_cfg_if.sink   cfg_i
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SETUP  = 7'b0000010,
    ST_SUM    = 7'b0000100,
    ST_DIVF   = 7'b0001000,
    ST_DIVS   = 7'b0010000,
    ST_DIVT   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  localparam logic signed [scr_pkg::TH_W-1:0] GAP_S =
    scr_pkg::TH_W'(scr_pkg::MIN_GAP);
  localparam logic signed [scr_pkg::TH_W-1:0] BUY_LO_S  = scr_pkg::TH_W'(scr_pkg::BUY_LO);
  localparam logic signed [scr_pkg::TH_W-1:0] BUY_HI_S  = scr_pkg::TH_W'(scr_pkg::BUY_HI);
  localparam logic signed [scr_pkg::TH_W-1:0] SELL_LO_S = scr_pkg::TH_W'(scr_pkg::SELL_LO);
  localparam logic signed [scr_pkg::TH_W-1:0] SELL_HI_S = scr_pkg::TH_W'(scr_pkg::SELL_HI);
  localparam logic signed [scr_pkg::TH_W-1:0] BUY_LO2_S = scr_pkg::TH_W'(2 * scr_pkg::BUY_LO);
  localparam logic signed [scr_pkg::TH_W-1:0] BUY_HI2_S = scr_pkg::TH_W'(2 * scr_pkg::BUY_HI);
  localparam logic signed [scr_pkg::TH_W-1:0] SELL_LO2_S =
    scr_pkg::TH_W'(2 * scr_pkg::SELL_LO);
  localparam logic signed [scr_pkg::TH_W-1:0] SELL_HI2_S =
    scr_pkg::TH_W'(2 * scr_pkg::SELL_HI);

  function automatic logic [scr_pkg::PER_W-1:0] eff_period(input logic [6:0] p);
    logic [scr_pkg::PER_W-1:0] r;
    if (p == 7'd0) begin
      r = scr_pkg::PER_W'(1);
    end else if (int'(p) > scr_pkg::MAX_PERIOD) begin
      r = scr_pkg::PER_W'(scr_pkg::MAX_PERIOD);
    end else begin
      r = scr_pkg::PER_W'(p);
    end
    return r;
  endfunction

  // configuration registers
  logic [6:0]  fast_period_q, slow_period_q;
  logic [7:0]  min_bars_q;
  logic        adapt_q;
  logic [15:0] base_buy_q, base_sell_q, up_bias_q, down_bias_q;

  // sequencer and state
  state_e                          state_q, state_d;
  logic [scr_pkg::RING_AW-1:0]     wp_q, wp_d;
  logic [scr_pkg::CNT_W-1:0]       hist_q, hist_d;
  logic [scr_pkg::PER_W-1:0]       fp_q, fp_d, sp_q, sp_d, len_q, len_d;
  logic                            fast_ok_q, fast_ok_d;
  logic [scr_pkg::PER_W-1:0]       issue_k_q, issue_k_d, dk_q, dk_d;
  logic                            issue_on_q, issue_on_d, dvld_q, dvld_d;
  logic [scr_pkg::SUM_W-1:0]       acc_q, acc_d, fsum_q, fsum_d, ssum_q, ssum_d;
  logic                            go_q, go_d;
  logic [scr_pkg::PRICE_W-1:0]     fast_avg_q, fast_avg_d, slow_avg_q, slow_avg_d;
  logic signed [scr_pkg::TREND_W-1:0] trend_q, trend_d;

  // output register
  logic                               out_valid_q, out_valid_d;
  logic [scr_pkg::PRICE_W-1:0]        out_fast_q, out_slow_q;
  logic signed [scr_pkg::TREND_W-1:0] out_trend_q;
  logic [scr_pkg::REGIME_W-1:0]       out_regime_q;
  logic [scr_pkg::LVL_W-1:0]          out_buy_q, out_sell_q;
  logic                               out_load;

  // datapath
  logic                            in_acc;
  logic                            ram_we;
  logic [scr_pkg::RING_AW-1:0]     ram_addr, rd_addr, k_ext;
  logic [scr_pkg::PRICE_W-1:0]     ram_rdata;
  logic [scr_pkg::SUM_W-1:0]       acc_new;
  logic [scr_pkg::PER_W-1:0]       fp_new, sp_new;
  logic [scr_pkg::CNT_W-1:0]       hist_inc, cap;
  scr_pkg::div_req_t               div_req;
  scr_pkg::div_rsp_t               div_rsp;
  logic                            neg;
  logic [scr_pkg::PRICE_W-1:0]     mag;
  logic [scr_pkg::TREND_W-1:0]     tq;
  scr_pkg::regime_e                regime;
  logic [scr_pkg::LVL_W-1:0]       buy_lvl, sell_lvl;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // ring addressing
  always_comb begin
    k_ext   = scr_pkg::RING_AW'(issue_k_q);
    rd_addr = (wp_q >= k_ext) ? wp_q - k_ext
                              : scr_pkg::RING_AW'(scr_pkg::RING_DEPTH - int'(k_ext) + int'(wp_q));
    ram_we   = in_acc;
    ram_addr = in_acc ? wp_q : rd_addr;
  end

  scr_ram #(
    .WIDTH (scr_pkg::PRICE_W),
    .DEPTH (scr_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.price),
    .rdata_o (ram_rdata)
  );

  // divider request
  always_comb begin
    neg = fast_avg_q < slow_avg_q;
    mag = neg ? slow_avg_q - fast_avg_q : fast_avg_q - slow_avg_q;
    div_req.start    = go_q && (state_q == ST_DIVF || state_q == ST_DIVS ||
                                state_q == ST_DIVT);
    div_req.dividend = scr_pkg::DIV_NW'({mag, 15'd0});
    div_req.divisor  = slow_avg_q;
    case (state_q)
      ST_DIVF: begin
        div_req.dividend = scr_pkg::DIV_NW'(fsum_q);
        div_req.divisor  = scr_pkg::DIV_DW'(fp_q);
      end
      ST_DIVS: begin
        div_req.dividend = scr_pkg::DIV_NW'(ssum_q);
        div_req.divisor  = scr_pkg::DIV_DW'(sp_q);
      end
      default: begin
        div_req.dividend = scr_pkg::DIV_NW'({mag, 15'd0});
        div_req.divisor  = slow_avg_q;
      end
    endcase
  end

  scr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (div_rsp.quotient > scr_pkg::DIV_NW'(scr_pkg::TREND_ONE)) begin
      tq = scr_pkg::TREND_W'(scr_pkg::TREND_ONE);
    end else begin
      tq = div_rsp.quotient[scr_pkg::TREND_W-1:0];
    end
  end

  // regime and threshold levels
  always_comb begin
    logic signed [scr_pkg::TH_W-1:0] tb, ts, tdiff, tsum, tb2, ts2;
    if (int'(hist_q) < int'(min_bars_q)) begin
      regime = scr_pkg::REGIME_NEUTRAL;
    end else if (fast_avg_q > slow_avg_q) begin
      regime = scr_pkg::REGIME_UP;
    end else if (fast_avg_q < slow_avg_q) begin
      regime = scr_pkg::REGIME_DOWN;
    end else begin
      regime = scr_pkg::REGIME_NEUTRAL;
    end
    tb = $signed({4'd0, base_buy_q});
    ts = $signed({4'd0, base_sell_q});
    case (regime)
      scr_pkg::REGIME_UP: begin
        tb = tb - $signed({4'd0, up_bias_q});
        ts = ts + $signed({4'd0, up_bias_q});
      end
      scr_pkg::REGIME_DOWN: begin
        tb = tb + $signed({4'd0, down_bias_q});
        ts = ts - $signed({4'd0, down_bias_q});
      end
      default: begin
      end
    endcase
    tdiff = tb - ts;
    tsum  = tb + ts;
    tb2   = tsum + GAP_S;
    ts2   = tsum - GAP_S;
    if (tdiff < GAP_S) begin
      if (tb2 < BUY_LO2_S) tb2 = BUY_LO2_S;
      if (tb2 > BUY_HI2_S) tb2 = BUY_HI2_S;
      if (ts2 < SELL_LO2_S) ts2 = SELL_LO2_S;
      if (ts2 > SELL_HI2_S) ts2 = SELL_HI2_S;
      tb = tb2 >>> 1;
      ts = ts2 >>> 1;
    end else begin
      if (tb < BUY_LO_S) tb = BUY_LO_S;
      if (tb > BUY_HI_S) tb = BUY_HI_S;
      if (ts < SELL_LO_S) ts = SELL_LO_S;
      if (ts > SELL_HI_S) ts = SELL_HI_S;
    end
    if (adapt_q) begin
      buy_lvl  = tb[scr_pkg::LVL_W-1:0];
      sell_lvl = ts[scr_pkg::LVL_W-1:0];
    end else begin
      buy_lvl  = base_buy_q;
      sell_lvl = base_sell_q;
    end
  end

  // sequencer
  always_comb begin
    fp_new   = eff_period(fast_period_q);
    sp_new   = eff_period(slow_period_q);
    hist_inc = hist_q + 1'b1;
    cap      = scr_pkg::CNT_W'({sp_new, 1'b0});
    acc_new  = acc_q + scr_pkg::SUM_W'(ram_rdata);

    state_d     = state_q;
    wp_d        = wp_q;
    hist_d      = hist_q;
    fp_d        = fp_q;
    sp_d        = sp_q;
    len_d       = len_q;
    fast_ok_d   = fast_ok_q;
    issue_k_d   = issue_k_q;
    issue_on_d  = issue_on_q;
    dvld_d      = 1'b0;
    dk_d        = dk_q;
    acc_d       = acc_q;
    fsum_d      = fsum_q;
    ssum_d      = ssum_q;
    go_d        = 1'b0;
    fast_avg_d  = fast_avg_q;
    slow_avg_d  = slow_avg_q;
    trend_d     = trend_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wp_d = (wp_q == scr_pkg::RING_AW'(scr_pkg::RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
          fp_d    = fp_new;
          sp_d    = sp_new;
          hist_d  = (hist_inc > cap) ? cap : hist_inc;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (hist_q >= scr_pkg::CNT_W'(sp_q)) begin
          fast_ok_d  = scr_pkg::CNT_W'(fp_q) <= hist_q;
          len_d      = (fast_ok_d && fp_q > sp_q) ? fp_q : sp_q;
          issue_k_d  = scr_pkg::PER_W'(1);
          issue_on_d = 1'b1;
          acc_d      = '0;
          state_d    = ST_SUM;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SUM: begin
        if (issue_on_q) begin
          dvld_d = 1'b1;
          dk_d   = issue_k_q;
          if (issue_k_q == len_q) begin
            issue_on_d = 1'b0;
          end else begin
            issue_k_d = issue_k_q + 1'b1;
          end
        end
        if (dvld_q) begin
          acc_d = acc_new;
          if (dk_q == fp_q) fsum_d = acc_new;
          if (dk_q == sp_q) ssum_d = acc_new;
          if (dk_q == len_q) begin
            state_d = ST_DIVF;
            go_d    = 1'b1;
          end
        end
      end
      ST_DIVF: begin
        if (div_rsp.done) begin
          fast_avg_d = fast_ok_q ? div_rsp.quotient[scr_pkg::PRICE_W-1:0] : '0;
          state_d    = ST_DIVS;
          go_d       = 1'b1;
        end
      end
      ST_DIVS: begin
        if (div_rsp.done) begin
          slow_avg_d = div_rsp.quotient[scr_pkg::PRICE_W-1:0];
          if (slow_avg_d != '0) begin
            state_d = ST_DIVT;
            go_d    = 1'b1;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_DIVT: begin
        if (div_rsp.done) begin
          trend_d = neg ? -$signed(tq) : $signed(tq);
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      hist_q      <= '0;
      issue_on_q  <= 1'b0;
      dvld_q      <= 1'b0;
      go_q        <= 1'b0;
      fast_avg_q  <= '0;
      slow_avg_q  <= '0;
      trend_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      hist_q      <= hist_d;
      issue_on_q  <= issue_on_d;
      dvld_q      <= dvld_d;
      go_q        <= go_d;
      fast_avg_q  <= fast_avg_d;
      slow_avg_q  <= slow_avg_d;
      trend_q     <= trend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fp_q      <= fp_d;
    sp_q      <= sp_d;
    len_q     <= len_d;
    fast_ok_q <= fast_ok_d;
    issue_k_q <= issue_k_d;
    dk_q      <= dk_d;
    acc_q     <= acc_d;
    fsum_q    <= fsum_d;
    ssum_q    <= ssum_d;
    if (out_load) begin
      out_fast_q   <= fast_avg_q;
      out_slow_q   <= slow_avg_q;
      out_trend_q  <= trend_q;
      out_regime_q <= regime;
      out_buy_q    <= buy_lvl;
      out_sell_q   <= sell_lvl;
    end
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_period_q <= scr_pkg::RST_FAST_PERIOD;
      slow_period_q <= scr_pkg::RST_SLOW_PERIOD;
      min_bars_q    <= scr_pkg::RST_MIN_BARS;
      adapt_q       <= scr_pkg::RST_ADAPT;
      base_buy_q    <= scr_pkg::RST_BASE_BUY;
      base_sell_q   <= scr_pkg::RST_BASE_SELL;
      up_bias_q     <= scr_pkg::RST_UP_BIAS;
      down_bias_q   <= scr_pkg::RST_DOWN_BIAS;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (scr_pkg::cfg_idx_e'(cfg_i.index))
        scr_pkg::CFG_FAST_PERIOD: fast_period_q <= cfg_i.data[6:0];
        scr_pkg::CFG_SLOW_PERIOD: slow_period_q <= cfg_i.data[6:0];
        scr_pkg::CFG_MIN_BARS:    min_bars_q    <= cfg_i.data[7:0];
        scr_pkg::CFG_ADAPT:       adapt_q       <= cfg_i.data[0];
        scr_pkg::CFG_BASE_BUY:    base_buy_q    <= cfg_i.data;
        scr_pkg::CFG_BASE_SELL:   base_sell_q   <= cfg_i.data;
        scr_pkg::CFG_UP_BIAS:     up_bias_q     <= cfg_i.data;
        scr_pkg::CFG_DOWN_BIAS:   down_bias_q   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.fast_average = out_fast_q;
  assign out_o.slow_average = out_slow_q;
  assign out_o.trend_ratio  = out_trend_q;
  assign out_o.regime       = out_regime_q;
  assign out_o.buy_level    = out_buy_q;
  assign out_o.sell_level   = out_sell_q;

endmodule

// ===== design/scr_ram.sv =====
// ----------------------------------------------------------------------------
// scr_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module scr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/scr_div.sv =====
// ----------------------------------------------------------------------------
// scr_div: shared radix-2 restoring divider
// Unsigned quotient, one bit per cycle, done pulses once at the end.
// ----------------------------------------------------------------------------
module scr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scr_pkg::div_req_t req_i,
  output scr_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [scr_pkg::DIV_CW-1:0]    cnt_q;
  logic [scr_pkg::DIV_DW-1:0]    rem_q;
  logic [scr_pkg::DIV_NW-1:0]    quo_q;
  logic [scr_pkg::DIV_DW-1:0]    dvs_q;
  logic [scr_pkg::DIV_DW:0]      trial;
  logic                          fits;
  logic [scr_pkg::DIV_DW-1:0]    rem_d;

  always_comb begin
    trial = {rem_q, quo_q[scr_pkg::DIV_NW-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? scr_pkg::DIV_DW'(trial - {1'b0, dvs_q}) : trial[scr_pkg::DIV_DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= scr_pkg::DIV_CW'(scr_pkg::DIV_NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == scr_pkg::DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[scr_pkg::DIV_NW-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== design/scr_checker.sv =====
// ----------------------------------------------------------------------------
// scr_checker: port-level checks of the regime detector
// Busy after a bar, stable stalled results, regime versus averages, range.
// ----------------------------------------------------------------------------
module scr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [scr_pkg::PRICE_W-1:0]        out_fast_i,
  input logic [scr_pkg::PRICE_W-1:0]        out_slow_i,
  input logic signed [scr_pkg::TREND_W-1:0] out_trend_i,
  input logic [scr_pkg::REGIME_W-1:0]       out_regime_i,
  input logic [scr_pkg::LVL_W-1:0]          out_buy_i,
  input logic [scr_pkg::LVL_W-1:0]          out_sell_i
);

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_fast_i) &&
    $stable(out_slow_i) && $stable(out_trend_i) && $stable(out_regime_i) &&
    $stable(out_buy_i) && $stable(out_sell_i))
    else $error("stalled result beat changed");

  a_regime_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_regime_i != scr_pkg::REGIME_UP || out_fast_i > out_slow_i) &&
      (out_regime_i != scr_pkg::REGIME_DOWN || out_fast_i < out_slow_i))
    else $error("regime disagrees with averages");

  a_trend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_trend_i >= -17'sd32768 && out_trend_i <= 17'sd32768)
    else $error("trend strength out of range");

  a_result_from_bar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result beat appeared while idle");

endmodule

bind sma_crossover_regime_detector scr_checker u_scr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_fast_i   (out_o.fast_average),
  .out_slow_i   (out_o.slow_average),
  .out_trend_i  (out_o.trend_ratio),
  .out_regime_i (out_o.regime),
  .out_buy_i    (out_o.buy_level),
  .out_sell_i   (out_o.sell_level)
);

// ===== test/sma_crossover_regime_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sma_crossover_regime_detector_test: bar-by-bar check of the regime detector
// Prices go in one beat per bar. An in-bench predictor keeps its own price
// history, averages, trend, regime and levels, and queues the expected result
// of every accepted bar. Each result beat is compared field by field. Directed
// bars cover the history fill, out-of-range periods, a lowered slow period and
// the threshold paths. Randomized runs of trending, flat and noisy prices
// follow under changing register settings, random source gaps and sink stalls,
// and one long output hold.
// ----------------------------------------------------------------------------
module sma_crossover_regime_detector_test;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int EXP_DEPTH   = 16;

  typedef struct packed {
    logic [scr_pkg::PRICE_W-1:0]        fast_average;
    logic [scr_pkg::PRICE_W-1:0]        slow_average;
    logic signed [scr_pkg::TREND_W-1:0] trend_ratio;
    scr_pkg::regime_e                   regime;
    logic [scr_pkg::LVL_W-1:0]          buy_level;
    logic [scr_pkg::LVL_W-1:0]          sell_level;
  } bar_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  scr_in_if  price_bus ();
  scr_out_if result_bus ();
  scr_cfg_if reg_bus ();

  sma_crossover_regime_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (price_bus),
    .out_o  (result_bus),
    .cfg_i  (reg_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic [6:0]                         fast_period_q = scr_pkg::RST_FAST_PERIOD;
  logic [6:0]                         slow_period_q = scr_pkg::RST_SLOW_PERIOD;
  logic [7:0]                         min_bars_q    = scr_pkg::RST_MIN_BARS;
  logic                               adapt_q       = scr_pkg::RST_ADAPT;
  logic [15:0]                        base_buy_q    = scr_pkg::RST_BASE_BUY;
  logic [15:0]                        base_sell_q   = scr_pkg::RST_BASE_SELL;
  logic [15:0]                        up_bias_q     = scr_pkg::RST_UP_BIAS;
  logic [15:0]                        down_bias_q   = scr_pkg::RST_DOWN_BIAS;
  logic [scr_pkg::PRICE_W-1:0]        price_hist [scr_pkg::RING_DEPTH];
  logic [scr_pkg::RING_AW-1:0]        hist_wptr = '0;
  int unsigned                        hist_count = 0;
  logic [scr_pkg::PRICE_W-1:0]        fast_avg_q = '0;
  logic [scr_pkg::PRICE_W-1:0]        slow_avg_q = '0;
  logic signed [scr_pkg::TREND_W-1:0] trend_q = '0;
  scr_pkg::regime_e                   regime_q = scr_pkg::REGIME_NEUTRAL;
  logic [scr_pkg::LVL_W-1:0]          buy_q = scr_pkg::RST_BASE_BUY;
  logic [scr_pkg::LVL_W-1:0]          sell_q = scr_pkg::RST_BASE_SELL;

  bar_result_t expected_bars [EXP_DEPTH];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;

  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_count = 0;
  int unsigned price_beats = 0;
  int unsigned result_beats = 0;
  int unsigned reg_writes = 0;

  function automatic int unsigned pending_bars();
    return exp_wr - exp_rd;
  endfunction

  function automatic void queue_bar(bar_result_t r);
    if (pending_bars() >= EXP_DEPTH) begin
      $error("expected result buffer overflow");
      error_count++;
    end
    expected_bars[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic int unsigned period_len(logic [6:0] p);
    if (p == 0) return 1;
    if (p > scr_pkg::MAX_PERIOD) return scr_pkg::MAX_PERIOD;
    return p;
  endfunction

  function automatic logic [scr_pkg::PRICE_W-1:0] newest_mean(int unsigned n);
    longint unsigned acc;
    logic [scr_pkg::RING_AW-1:0] idx;
    if (n == 0 || n > hist_count) return '0;
    acc = 0;
    idx = hist_wptr;
    for (int unsigned k = 0; k < n; k++) begin
      idx = idx - 1'b1;
      acc += price_hist[idx];
    end
    return scr_pkg::PRICE_W'(acc / n);
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bar_result_t advance_bar(logic [scr_pkg::PRICE_W-1:0] price);
    int unsigned fast_len;
    int unsigned slow_len;
    longint fa, sa, diff, mag, buy, sell, total, up, down;
    bar_result_t r;
    fast_len = period_len(fast_period_q);
    slow_len = period_len(slow_period_q);
    price_hist[hist_wptr] = price;
    hist_wptr = hist_wptr + 1'b1;
    hist_count = (hist_count + 1 > 2 * slow_len) ? 2 * slow_len : hist_count + 1;
    if (hist_count >= slow_len) begin
      fast_avg_q = newest_mean(fast_len);
      slow_avg_q = newest_mean(slow_len);
      if (slow_avg_q != 0) begin
        fa = fast_avg_q;
        sa = slow_avg_q;
        diff = fa - sa;
        mag = (diff < 0) ? -diff : diff;
        mag = (mag * scr_pkg::TREND_ONE) / sa;
        if (mag > scr_pkg::TREND_ONE) mag = scr_pkg::TREND_ONE;
        trend_q = scr_pkg::TREND_W'((diff < 0) ? -mag : mag);
      end
    end
    if (hist_count < min_bars_q) regime_q = scr_pkg::REGIME_NEUTRAL;
    else if (fast_avg_q > slow_avg_q) regime_q = scr_pkg::REGIME_UP;
    else if (fast_avg_q < slow_avg_q) regime_q = scr_pkg::REGIME_DOWN;
    else regime_q = scr_pkg::REGIME_NEUTRAL;
    if (adapt_q) begin
      buy = base_buy_q;
      sell = base_sell_q;
      up = up_bias_q;
      down = down_bias_q;
      if (regime_q == scr_pkg::REGIME_UP) begin
        buy = buy - up;
        sell = sell + up;
      end else if (regime_q == scr_pkg::REGIME_DOWN) begin
        buy = buy + down;
        sell = sell - down;
      end
      if (buy - sell < scr_pkg::MIN_GAP) begin
        total = buy + sell;
        buy = clamp_to(total + scr_pkg::MIN_GAP, 2 * scr_pkg::BUY_LO,
                       2 * scr_pkg::BUY_HI) / 2;
        sell = clamp_to(total - scr_pkg::MIN_GAP, 2 * scr_pkg::SELL_LO,
                        2 * scr_pkg::SELL_HI) / 2;
      end else begin
        buy = clamp_to(buy, scr_pkg::BUY_LO, scr_pkg::BUY_HI);
        sell = clamp_to(sell, scr_pkg::SELL_LO, scr_pkg::SELL_HI);
      end
      buy_q = scr_pkg::LVL_W'(buy);
      sell_q = scr_pkg::LVL_W'(sell);
    end else begin
      buy_q = base_buy_q;
      sell_q = base_sell_q;
    end
    r.fast_average = fast_avg_q;
    r.slow_average = slow_avg_q;
    r.trend_ratio = trend_q;
    r.regime = regime_q;
    r.buy_level = buy_q;
    r.sell_level = sell_q;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  // sink side: stall at random, or hold off for a counted stretch
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      result_bus.ready = 1'b0;
      hold_left--;
    end else begin
      result_bus.ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    bar_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      result_beats++;
      if (pending_bars() == 0) begin
        $error("result beat with no bar outstanding");
        error_count++;
      end else begin
        want = expected_bars[exp_rd % EXP_DEPTH];
        exp_rd++;
        compare_field("fast_average", want.fast_average, result_bus.fast_average);
        compare_field("slow_average", want.slow_average, result_bus.slow_average);
        compare_field("trend_ratio", 32'(want.trend_ratio),
                      32'(result_bus.trend_ratio));
        compare_field("regime", 32'(want.regime), 32'(result_bus.regime));
        compare_field("buy_level", 32'(want.buy_level), 32'(result_bus.buy_level));
        compare_field("sell_level", 32'(want.sell_level), 32'(result_bus.sell_level));
      end
    end
  end

  // the longest bar plus the long output hold stays well below the limit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((price_bus.valid && price_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (reg_bus.valid && reg_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("sma_crossover_regime_detector_test: errors");
        $finish;
      end
    end
  end

  task automatic send_price(input logic [scr_pkg::PRICE_W-1:0] price);
    while ($urandom_range(99) < in_idle_pct) begin
      price_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    price_bus.valid = 1'b1;
    price_bus.price = price;
    do @(posedge clk_i); while (!price_bus.ready);
    queue_bar(advance_bar(price));
    price_beats++;
    @(negedge clk_i);
  endtask

  task automatic drain_bars();
    price_bus.valid = 1'b0;
    while (pending_bars() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [6:0] fast, input logic [6:0] slow,
                          input logic [7:0] bars, input logic adapt,
                          input logic [15:0] buy, input logic [15:0] sell,
                          input logic [15:0] up, input logic [15:0] down);
    logic [15:0] vals [8];
    scr_pkg::cfg_idx_e idx;
    vals = '{16'(fast), 16'(slow), 16'(bars), 16'(adapt), buy, sell, up, down};
    for (int i = 0; i < 8; i++) begin
      idx = scr_pkg::cfg_idx_e'(i);
      reg_bus.valid = 1'b1;
      reg_bus.index = idx;
      reg_bus.data = vals[i];
      do @(posedge clk_i); while (!reg_bus.ready);
      case (idx)
        scr_pkg::CFG_FAST_PERIOD: fast_period_q = vals[i][6:0];
        scr_pkg::CFG_SLOW_PERIOD: slow_period_q = vals[i][6:0];
        scr_pkg::CFG_MIN_BARS:    min_bars_q = vals[i][7:0];
        scr_pkg::CFG_ADAPT:       adapt_q = vals[i][0];
        scr_pkg::CFG_BASE_BUY:    base_buy_q = vals[i];
        scr_pkg::CFG_BASE_SELL:   base_sell_q = vals[i];
        scr_pkg::CFG_UP_BIAS:     up_bias_q = vals[i];
        scr_pkg::CFG_DOWN_BIAS:   down_bias_q = vals[i];
        default: ;
      endcase
      reg_writes++;
      @(negedge clk_i);
    end
    reg_bus.valid = 1'b0;
  endtask

  function automatic logic [6:0] pick_period();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'(scr_pkg::MAX_PERIOD);
      3: return 7'($urandom_range(scr_pkg::MAX_PERIOD + 1, 127));
      4, 5, 6: return 7'($urandom_range(1, 8));
      7, 8: return 7'($urandom_range(1, 20));
      default: return 7'($urandom_range(1, scr_pkg::MAX_PERIOD));
    endcase
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(20000, 45000));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_bias();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'd32768;
      2, 3: return 16'($urandom_range(0, 8000));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_history_fill();
    drain_bars();
    set_regs(7'd2, 7'd3, 8'd3, 1'b1, scr_pkg::RST_BASE_BUY, scr_pkg::RST_BASE_SELL,
             scr_pkg::RST_UP_BIAS, scr_pkg::RST_DOWN_BIAS);
    send_price('0);
    send_price('1);
    send_price('1);
    send_price('0);
    send_price('0);
    send_price('1);
  endtask

  task automatic test_period_limits();
    drain_bars();
    set_regs(7'd127, 7'd2, 8'd0, 1'b1, scr_pkg::RST_BASE_BUY, scr_pkg::RST_BASE_SELL,
             scr_pkg::RST_UP_BIAS, scr_pkg::RST_DOWN_BIAS);
    send_price(32'd0);
    send_price(32'd0);
    send_price(32'd1);
    send_price(32'd2);
    send_price(32'd3);
    drain_bars();
    set_regs(7'd0, 7'd0, 8'd0, 1'b1, scr_pkg::RST_BASE_BUY, scr_pkg::RST_BASE_SELL,
             scr_pkg::RST_UP_BIAS, scr_pkg::RST_DOWN_BIAS);
    send_price(32'd7);
    send_price(32'd5);
  endtask

  task automatic test_slow_shrink();
    drain_bars();
    set_regs(7'd3, 7'd5, 8'd0, 1'b1, scr_pkg::RST_BASE_BUY, scr_pkg::RST_BASE_SELL,
             scr_pkg::RST_UP_BIAS, scr_pkg::RST_DOWN_BIAS);
    for (int k = 1; k <= 7; k++) send_price(32'(k * 1000));
    drain_bars();
    set_regs(7'd3, 7'd1, 8'd0, 1'b1, scr_pkg::RST_BASE_BUY, scr_pkg::RST_BASE_SELL,
             scr_pkg::RST_UP_BIAS, scr_pkg::RST_DOWN_BIAS);
    send_price(32'd9000);
    send_price(32'd500);
  endtask

  task automatic test_threshold_paths();
    drain_bars();
    set_regs(7'd1, 7'd2, 8'd0, 1'b0, 16'hFFFF, 16'h0000, 16'd32768, 16'd32768);
    send_price(32'd100);
    drain_bars();
    set_regs(7'd1, 7'd2, 8'd0, 1'b1, 16'h0000, 16'hFFFF, 16'd32768, 16'd32768);
    send_price(32'd10);
    send_price(32'd20);
    send_price(32'd5);
  endtask

  task automatic test_random_bars(input int unsigned bar_target, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned sent;
    int unsigned run_len;
    int unsigned shape;
    int unsigned step_max;
    logic [6:0] slow;
    logic [7:0] bars;
    logic [scr_pkg::PRICE_W-1:0] level;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < bar_target) begin
      drain_bars();
      slow = pick_period();
      case ($urandom_range(5))
        0: bars = 8'd0;
        1: bars = 8'd128;
        2: bars = 8'd255;
        default: bars = 8'($urandom_range(0, 2 * period_len(slow) + 2));
      endcase
      set_regs(pick_period(), slow, bars, $urandom_range(3) != 0, pick_level(),
               pick_level(), pick_bias(), pick_bias());
      run_len = 2 * period_len(slow) + $urandom_range(2, 20);
      shape = $urandom_range(5);
      step_max = 1 << $urandom_range(0, 24);
      level = (shape == 4) ? '0 : $urandom();
      for (int unsigned k = 0; k < run_len; k++) begin
        case (shape)
          0: level += $urandom_range(0, step_max);
          1: level -= $urandom_range(0, step_max);
          2: level = $urandom();
          4: level = $urandom_range(0, 3);
          5: begin
            if (k < run_len / 2) level += $urandom_range(0, step_max);
            else level -= $urandom_range(0, step_max);
          end
          default: ;
        endcase
        send_price(level);
        sent++;
      end
    end
  endtask

  task automatic test_output_hold();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (12) send_price($urandom());
  endtask

  initial begin
    rst_ni = 1'b0;
    price_bus.valid = 1'b0;
    price_bus.price = '0;
    result_bus.ready = 1'b0;
    reg_bus.valid = 1'b0;
    reg_bus.index = scr_pkg::CFG_FAST_PERIOD;
    reg_bus.data = '0;
    in_idle_pct = 8;
    out_stall_pct = 62;
    for (int i = 0; i < scr_pkg::RING_DEPTH; i++) price_hist[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_history_fill();
    test_period_limits();
    test_slow_shrink();
    test_threshold_paths();
    test_random_bars(300, 8, 62);
    test_random_bars(300, 62, 8);
    test_output_hold();
    test_random_bars(280, 0, 0);

    drain_bars();
    repeat (300) @(posedge clk_i);
    if (pending_bars() != 0) begin
      $error("%0d bars left without a result", pending_bars());
      error_count++;
    end
    $display("run: %0d price beats, %0d result beats, %0d register writes",
             price_beats, result_beats, reg_writes);
    $display("run: periods 0 to 127, fill and shrink, both adapt modes, %0d-cycle hold",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("sma_crossover_regime_detector_test: clean");
    end else begin
      $display("sma_crossover_regime_detector_test: errors");
    end
    $finish;
  end

endmodule

// ===== sma_crossover_regime_detector.f =====
design/scr_pkg.sv
design/scr_if.sv
design/scr_ram.sv
design/scr_div.sv
design/sma_crossover_regime_detector.sv
design/scr_checker.sv
test/sma_crossover_regime_detector_test.sv
